// ===== rtl/core/cht_pkg.sv =====
// Shared types, constants and state codes for the chained hash table.
`default_nettype none
package cht_pkg;
  localparam int NumBuckets = 128;
  localparam int PoolSize   = 256;
  localparam int BucketW    = $clog2(NumBuckets);
  localparam int NodeW      = $clog2(PoolSize);
  localparam int PtrW       = NodeW + 1;
  localparam int CountW     = $clog2(NumBuckets + 1);
  localparam logic [PtrW-1:0] NilPtr = PtrW'(PoolSize);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]   action;
    logic signed [31:0] req_key;
    logic signed [31:0] req_value;
  } req_t;

  typedef struct packed {
    logic [2:0]   status;
    logic signed [31:0] found_value;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_HEAD, S_HEADW, S_READ, S_READW, S_CMP, S_ACT, S_UNLINK, S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture request, start remainder
    logic mod_step;   // one remainder step
    logic head_rd;    // read bucket head into cursor
    logic node_rd;    // read node at cursor
    logic advance;    // prev <= cur, cur <= link
    logic commit;     // perform action on match/miss
    logic unlink;     // second write of a remove
    logic out_load;   // register the response
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mod_done;
    logic cur_nil;
    logic key_hit;
    logic steps_done;
    logic need_unlink;
  } stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/cht_ctrl.sv =====
// Controller state machine that sequences one request through the datapath.
`default_nettype none
module cht_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_fire,
  input  wire logic          out_busy,
  input  wire cht_pkg::stat_t st,
  output cht_pkg::cmd_t      cmd,
  output logic               idle
);
  cht_pkg::state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= cht_pkg::S_IDLE;
    else     state <= state_next;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      cht_pkg::S_IDLE:   if (in_fire) state_next = cht_pkg::S_MOD;
      cht_pkg::S_MOD:    if (st.mod_done) state_next = cht_pkg::S_HEAD;
      cht_pkg::S_HEAD:   state_next = cht_pkg::S_HEADW;
      cht_pkg::S_HEADW:  state_next = cht_pkg::S_READ;
      cht_pkg::S_READ:   state_next = st.cur_nil ? cht_pkg::S_ACT : cht_pkg::S_READW;
      cht_pkg::S_READW:  state_next = cht_pkg::S_CMP;
      cht_pkg::S_CMP:    state_next = (st.key_hit || st.steps_done) ? cht_pkg::S_ACT
                                                                    : cht_pkg::S_READ;
      cht_pkg::S_ACT:    state_next = st.need_unlink ? cht_pkg::S_UNLINK : cht_pkg::S_OUT;
      cht_pkg::S_UNLINK: state_next = cht_pkg::S_OUT;
      cht_pkg::S_OUT:    if (!out_busy) state_next = cht_pkg::S_IDLE;
      default:           state_next = cht_pkg::S_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    cmd  = '0;
    idle = 1'b0;
    unique case (state)
      cht_pkg::S_IDLE:   begin idle = 1'b1; cmd.load = in_fire; end
      cht_pkg::S_MOD:    cmd.mod_step = 1'b1;
      cht_pkg::S_HEAD:   cmd.head_rd = 1'b1;
      cht_pkg::S_READ:   cmd.node_rd = !st.cur_nil;
      cht_pkg::S_CMP:    cmd.advance = !st.key_hit && !st.steps_done;
      cht_pkg::S_ACT:    cmd.commit = 1'b1;
      cht_pkg::S_UNLINK: cmd.unlink = 1'b1;
      cht_pkg::S_OUT:    cmd.out_load = !out_busy;
      default:           ;
    endcase
  end

  // A response is loaded only from the output state.
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> $past(state_next) == cht_pkg::S_OUT || state == cht_pkg::S_OUT)
    else $error("response loaded outside output state");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == cht_pkg::S_MOD)
    else $error("load did not start remainder");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one command");
endmodule
`default_nettype wire

// ===== rtl/core/cht_dpath.sv =====
// Datapath: remainder unit, bucket heads, node memories, free list and response.
`default_nettype none
module cht_dpath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire cht_pkg::cmd_t  cmd,
  input  wire cht_pkg::req_t  req,
  input  wire logic [7:0]     cfg_buckets,
  output cht_pkg::stat_t      st,
  output cht_pkg::rsp_t       rsp
);
  localparam int PW = cht_pkg::PtrW;
  localparam int NW = cht_pkg::NodeW;
  localparam int BW = cht_pkg::BucketW;
  localparam int CW = cht_pkg::CountW;

  // Captured request.
  logic [1:0]  act;
  logic [31:0] key, val;

  // Effective bucket count: zero becomes one, large values saturate.
  logic [CW-1:0] nb;
  always_comb begin
    if (cfg_buckets == 8'd0) nb = CW'(1);
    else if ({1'b0, cfg_buckets} > 9'(cht_pkg::NumBuckets)) nb = CW'(cht_pkg::NumBuckets);
    else nb = CW'(cfg_buckets);
  end

  // Restoring remainder of |key| by nb, one bit a step.
  logic [32:0]   mag;
  logic [CW-1:0] rem;
  logic [CW-1:0] nbr;
  logic [5:0]    bitn;
  logic          neg;
  logic [CW:0]   trial;
  assign trial = {rem, mag[32]};
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= req.action;
      key  <= req.req_key;
      val  <= req.req_value;
      neg  <= req.req_key[31];
      mag  <= req.req_key[31] ? 33'(-{1'b1, req.req_key}) : {1'b0, req.req_key};
      rem  <= '0;
      nbr  <= nb;
      bitn <= 6'd0;
    end else if (cmd.mod_step && bitn != 6'd33) begin
      mag  <= {mag[31:0], 1'b0};
      bitn <= bitn + 6'd1;
      rem  <= (trial >= {1'b0, nbr}) ? CW'(trial - {1'b0, nbr}) : CW'(trial);
    end
  end
  assign st.mod_done = (bitn == 6'd33);

  logic [BW-1:0] bkt;
  always_comb begin
    if (neg && rem != '0) bkt = BW'(nbr - rem);
    else                  bkt = BW'(rem);
  end

  // Bucket head memory with valid bits.
  logic [PW-1:0]         heads [cht_pkg::NumBuckets];
  logic [cht_pkg::NumBuckets-1:0] head_vld;
  logic [PW-1:0]         head_q;
  logic                  head_wr;
  logic [PW-1:0]         head_wd;
  logic [BW-1:0]         bkt_q;
  always_ff @(posedge clk) begin
    if (head_wr) heads[bkt_q] <= head_wd;
    head_q <= heads[bkt];
  end
  always_ff @(posedge clk) begin
    if (rst) head_vld <= '0;
    else if (head_wr) head_vld[bkt_q] <= 1'b1;
  end

  // Node memories.
  logic [31:0]   mkey [cht_pkg::PoolSize];
  logic [31:0]   mval [cht_pkg::PoolSize];
  logic [PW-1:0] mlnk [cht_pkg::PoolSize];
  logic [31:0]   rkey, rval;
  logic [PW-1:0] rlnk;
  logic [NW-1:0] raddr;
  logic          kv_wr, val_wr, lnk_wr;
  logic [NW-1:0] kv_addr, lnk_addr;
  logic [PW-1:0] lnk_wd;
  always_ff @(posedge clk) begin
    if (kv_wr) mkey[kv_addr] <= key;
    if (val_wr) mval[kv_addr] <= val;
    if (lnk_wr) mlnk[lnk_addr] <= lnk_wd;
    rkey <= mkey[raddr];
    rval <= mval[raddr];
    rlnk <= mlnk[raddr];
  end

  // Chain walk registers.
  logic [PW-1:0] cur, prv, free_head, unl_prev, unl_prev_lnk;
  logic [PW-1:0] never_used;
  logic [PW-1:0] steps;
  logic [PW-1:0] walk_head;
  logic          head_rd_q;
  assign st.cur_nil    = cur[PW-1];
  assign st.key_hit    = (rkey == key);
  assign st.steps_done = (steps == PW'(cht_pkg::PoolSize));
  assign raddr = cur[NW-1:0];
  always_ff @(posedge clk) begin
    head_rd_q <= cmd.head_rd;
    if (cmd.head_rd) begin
      bkt_q <= bkt;
      prv   <= cht_pkg::NilPtr;
      steps <= '0;
    end
    // The chain head is kept for linking a new node in front of it.
    if (head_rd_q) begin
      cur       <= head_vld[bkt_q] ? head_q : cht_pkg::NilPtr;
      walk_head <= head_vld[bkt_q] ? head_q : cht_pkg::NilPtr;
    end
    if (cmd.advance) begin
      prv   <= cur;
      cur   <= rlnk;
      steps <= steps + PW'(1);
    end
  end

  // A hit exists when the walk stopped on a node with a matching key.
  logic hit;
  assign hit = !st.cur_nil && st.key_hit;
  logic          have_free;
  logic [PW-1:0] fresh;
  assign have_free = !free_head[PW-1] || (never_used != PW'(cht_pkg::PoolSize));
  assign fresh     = !free_head[PW-1] ? free_head : never_used;
  logic [2:0]  res_st;
  logic [31:0] res_val;
  logic        rem_hit;
  assign st.need_unlink = (act == cht_pkg::ACT_REMOVE) && hit;

  // Action, memory writes and free list update.
  always_comb begin
    kv_wr = 1'b0; val_wr = 1'b0; lnk_wr = 1'b0;
    head_wr = 1'b0; head_wd = cht_pkg::NilPtr;
    kv_addr = cur[NW-1:0]; lnk_addr = cur[NW-1:0]; lnk_wd = rlnk;
    if (cmd.commit) begin
      case (act)
        cht_pkg::ACT_INSERT: begin
          if (hit) val_wr = 1'b1;
          else if (have_free) begin
            kv_wr = 1'b1; val_wr = 1'b1; lnk_wr = 1'b1;
            kv_addr = fresh[NW-1:0]; lnk_addr = fresh[NW-1:0];
            lnk_wd = walk_head;
            head_wr = 1'b1; head_wd = fresh;
          end
        end
        cht_pkg::ACT_REMOVE: begin
          if (hit) begin
            lnk_wr = 1'b1; lnk_wd = free_head;
            if (prv[PW-1]) begin head_wr = 1'b1; head_wd = rlnk; end
          end
        end
        default: ;
      endcase
    end else if (cmd.unlink && !unl_prev[PW-1]) begin
      lnk_wr = 1'b1; lnk_addr = unl_prev[NW-1:0]; lnk_wd = unl_prev_lnk;
    end
  end

  // Link of the free list head, read well ahead of the next commit.
  logic [PW-1:0] rlnk_free;
  always_ff @(posedge clk) begin
    rlnk_free <= mlnk[free_head[NW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head  <= cht_pkg::NilPtr;
      never_used <= '0;
    end else if (cmd.commit) begin
      if (act == cht_pkg::ACT_INSERT && !hit && have_free) begin
        if (!free_head[PW-1]) free_head <= rlnk_free;
        else never_used <= never_used + PW'(1);
      end else if (act == cht_pkg::ACT_REMOVE && hit) begin
        free_head <= cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      unl_prev     <= prv;
      unl_prev_lnk <= rlnk;
      rem_hit      <= hit;
      res_val      <= '0;
      case (act)
        cht_pkg::ACT_INSERT: res_st <= hit ? cht_pkg::ST_UPDATED
                                     : (have_free ? cht_pkg::ST_INSERTED : cht_pkg::ST_FULL);
        cht_pkg::ACT_SEARCH: begin
          res_st  <= hit ? cht_pkg::ST_FOUND : cht_pkg::ST_NOT_FOUND;
          res_val <= hit ? rval : 32'd0;
        end
        cht_pkg::ACT_REMOVE: res_st <= hit ? cht_pkg::ST_REMOVED : cht_pkg::ST_NOT_FOUND;
        default:             res_st <= cht_pkg::ST_NOT_FOUND;
      endcase
    end
  end

  assign rsp.status      = res_st;
  assign rsp.found_value = res_val;

  // Found value is zero for every status but found.
  a_val_zero: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.commit) && res_st != cht_pkg::ST_FOUND |-> res_val == 32'd0)
    else $error("nonzero value without found");
  a_unlink_rm: assert property (@(posedge clk) disable iff (rst)
    cmd.unlink |-> rem_hit)
    else $error("unlink without a hit");
  a_bkt_range: assert property (@(posedge clk) disable iff (rst)
    cmd.head_rd |-> CW'(bkt) < nbr)
    else $error("bucket out of range");
endmodule
`default_nettype wire

// ===== rtl/core/chained_hash_table_core.sv =====
// Top level of the chained hash table: channels, config register and output stage.
//
//  channel  | signals                       | direction
//  req      | req_valid req_ready req_data  | in
//  rsp      | rsp_valid rsp_ready rsp_data  | out
//  cfg      | cfg_valid cfg_ready cfg_data  | in
//
// A request passes from the accepting edge to the result word through the bit-serial remainder,
// the head read (S_HEAD, S_HEADW), S_READ, S_READW and S_CMP for each node compared, a last
// S_READ when the walk runs off the end of the chain, S_ACT, S_UNLINK when a remove unlinks
// a node, and the load of the output register in S_OUT.
// Reset is synchronous; it empties all buckets and the free list at once.
// The result word sits in an output register; a stalled output holds the core in its last state.
`default_nettype none
module chained_hash_table_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire cht_pkg::req_t req_data,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output cht_pkg::rsp_t      rsp_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [7:0]    cfg_data
);
  logic [7:0]     bucket_count;
  cht_pkg::cmd_t  cmd;
  cht_pkg::stat_t st;
  cht_pkg::rsp_t  rsp_core;
  logic           idle;

  // Configuration register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) bucket_count <= 8'd128;
    else if (cfg_valid) bucket_count <= cfg_data;
  end

  assign req_ready = idle;

  cht_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(req_valid && req_ready),
    .out_busy(rsp_valid && !rsp_ready), .st(st), .cmd(cmd), .idle(idle)
  );

  cht_dpath u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .req(req_data),
    .cfg_buckets(bucket_count), .st(st), .rsp(rsp_core)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (cmd.out_load) rsp_valid <= 1'b1;
    else if (rsp_ready) rsp_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) rsp_data <= rsp_core;
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !cmd.out_load)
    else $error("response overwritten");
endmodule
`default_nettype wire
